// ===== hw/rtl/ipv4hc_pkg.sv =====
// Shared types and constants for the IPv4 header checker.
package ipv4hc_pkg;

    typedef enum logic [3:0] {
        ST_UDP           = 4'd0,
        ST_ICMP          = 4'd1,
        ST_TCP           = 4'd2,
        ST_UNKNOWN_PROTO = 4'd3,
        ST_BAD_VERSION   = 4'd4,
        ST_BAD_HDR_LEN   = 4'd5,
        ST_BAD_CHECKSUM  = 4'd6,
        ST_BAD_TOTAL_LEN = 4'd7,
        ST_FRAGMENT      = 4'd8
    } status_t;

    localparam logic [7:0]  PROTO_ICMP    = 8'd1;
    localparam logic [7:0]  PROTO_TCP     = 8'd6;
    localparam logic [7:0]  PROTO_UDP     = 8'd17;
    localparam logic [3:0]  IP_VERSION    = 4'd4;
    localparam logic [5:0]  MIN_HDR_LEN   = 6'd20;
    localparam logic [15:0] COUNT_MAX     = 16'hffff;
    localparam logic [12:0] NO_FRAG_OFS   = 13'd0;

    // header byte offsets
    localparam logic [15:0] OFS_VER_IHL   = 16'd0;
    localparam logic [15:0] OFS_TLEN_HI   = 16'd2;
    localparam logic [15:0] OFS_TLEN_LO   = 16'd3;
    localparam logic [15:0] OFS_ID_HI     = 16'd4;
    localparam logic [15:0] OFS_ID_LO     = 16'd5;
    localparam logic [15:0] OFS_FRAG_HI   = 16'd6;
    localparam logic [15:0] OFS_FRAG_LO   = 16'd7;
    localparam logic [15:0] OFS_TTL       = 16'd8;
    localparam logic [15:0] OFS_PROTO     = 16'd9;
    localparam logic [15:0] OFS_CSUM_HI   = 16'd10;
    localparam logic [15:0] OFS_CSUM_LO   = 16'd11;
    localparam logic [15:0] OFS_SRC       = 16'd12;
    localparam logic [15:0] OFS_DST       = 16'd16;
    localparam logic [15:0] OFS_HDR_END   = 16'd20;

    // latched header plus running sum, as seen by the verdict logic
    typedef struct packed {
        logic [7:0]  first_byte;
        logic [15:0] checksum;
        logic [15:0] tot_len;
        logic [15:0] identification;
        logic [15:0] flags_offset;
        logic [7:0]  ttl;
        logic [7:0]  protocol;
        logic [31:0] source;
        logic [31:0] destination;
        logic [15:0] sum;
    } hdr_t;

endpackage

// ===== hw/rtl/ipv4hc_ifs.sv =====
// Handshake interfaces for the byte input and the verdict output.
interface ipv4hc_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_value;
    logic       last_byte;

    modport source (output valid, output byte_value, output last_byte, input ready);
    modport sink (input valid, input byte_value, input last_byte, output ready);
endinterface

interface ipv4hc_verdict_if;
    logic        valid;
    logic        ready;
    logic [3:0]  status;
    logic [7:0]  protocol_number;
    logic [15:0] tot_len;
    logic [5:0]  header_length;
    logic [15:0] identification;
    logic [2:0]  flag_bits;
    logic [7:0]  ttl_value;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;

    modport source (
        output valid, output status, output protocol_number, output tot_len,
        output header_length, output identification, output flag_bits,
        output ttl_value, output src_addr, output dst_addr,
        input ready
    );
    modport sink (
        input valid, input status, input protocol_number, input tot_len,
        input header_length, input identification, input flag_bits,
        input ttl_value, input src_addr, input dst_addr,
        output ready
    );
endinterface

// ===== hw/rtl/ipv4hc_verdict.sv =====
// Prioritized header checks and protocol classification for one packet.
module ipv4hc_verdict (
    input  ipv4hc_pkg::hdr_t    hdr,
    input  logic [15:0]         received,
    output ipv4hc_pkg::status_t status
);
    import ipv4hc_pkg::*;

    logic [5:0]  hlen;
    logic [15:0] calc;

    assign hlen = {hdr.first_byte[3:0], 2'b00};
    assign calc = ~hdr.sum;

    always_comb
    begin
        priority if (hdr.first_byte[7:4] != IP_VERSION)
            status = ST_BAD_VERSION;
        else if (hlen < MIN_HDR_LEN || {10'd0, hlen} > received)
            status = ST_BAD_HDR_LEN;
        else if (hdr.checksum != calc)
            status = ST_BAD_CHECKSUM;
        else if (hdr.tot_len > received)
            status = ST_BAD_TOTAL_LEN;
        else if (hdr.flags_offset[12:0] != NO_FRAG_OFS)
            status = ST_FRAGMENT;
        else if (hdr.protocol == PROTO_UDP)
            status = ST_UDP;
        else if (hdr.protocol == PROTO_ICMP)
            status = ST_ICMP;
        else if (hdr.protocol == PROTO_TCP)
            status = ST_TCP;
        else
            status = ST_UNKNOWN_PROTO;
    end

endmodule

// ===== hw/rtl/ipv4_header_checker.sv =====
// IPv4 header checker: takes a packet one byte per clock while input ready is high
// and gives a verdict word after the final byte. Packets may run back to back with
// no gap; the verdict word enters the output register in the cycle after the final
// byte is accepted. The byte count, running ones'-complement sum and latched header
// fields update in the same cycle a byte is accepted, so the next byte can follow at
// once. Input ready drops only while a verdict word waits in the output register and
// the sink is not taking it. The byte count saturates at 65535; later bytes are
// counted as nothing and latch nothing.
module ipv4_header_checker (
    input logic              clk,
    input logic              rst_n,
    ipv4hc_byte_if.sink      byte_in,
    ipv4hc_verdict_if.source verdict
);
    import ipv4hc_pkg::*;

    logic [15:0] count_reg, count_next;
    logic [7:0]  pending_reg, pending_next;
    hdr_t        hdr_reg, hdr_next;

    logic        out_valid_reg, out_valid_next;
    status_t     status_reg;
    hdr_t        out_hdr_reg;

    logic        accept;
    logic        done;
    logic [5:0]  hlen_cur;
    logic [15:0] word;
    logic [16:0] sum_wide;
    logic [15:0] sum_folded;
    status_t     status_next;

    assign byte_in.ready = !out_valid_reg || verdict.ready;
    assign accept        = byte_in.valid && byte_in.ready;
    assign done          = accept && byte_in.last_byte;

    assign hlen_cur   = {hdr_reg.first_byte[3:0], 2'b00};
    assign word       = {pending_reg, byte_in.byte_value};
    assign sum_wide   = {1'b0, hdr_reg.sum} + {1'b0, word};
    // end-around carry; the sum never exceeds 16 bits after the fold
    assign sum_folded = sum_wide[16] ? (sum_wide[15:0] + 16'd1) : sum_wide[15:0];

    // header state after this byte
    always_comb
    begin
        hdr_next     = hdr_reg;
        count_next   = count_reg;
        pending_next = pending_reg;
        if (accept && count_reg != COUNT_MAX)
        begin
            count_next = count_reg + 16'd1;
            unique case (count_reg)
                OFS_VER_IHL: hdr_next.first_byte           = byte_in.byte_value;
                OFS_TLEN_HI: hdr_next.tot_len[15:8]        = byte_in.byte_value;
                OFS_TLEN_LO: hdr_next.tot_len[7:0]         = byte_in.byte_value;
                OFS_ID_HI:   hdr_next.identification[15:8] = byte_in.byte_value;
                OFS_ID_LO:   hdr_next.identification[7:0]  = byte_in.byte_value;
                OFS_FRAG_HI: hdr_next.flags_offset[15:8]   = byte_in.byte_value;
                OFS_FRAG_LO: hdr_next.flags_offset[7:0]    = byte_in.byte_value;
                OFS_TTL:     hdr_next.ttl                  = byte_in.byte_value;
                OFS_PROTO:   hdr_next.protocol             = byte_in.byte_value;
                OFS_CSUM_HI: hdr_next.checksum[15:8]       = byte_in.byte_value;
                OFS_CSUM_LO: hdr_next.checksum[7:0]        = byte_in.byte_value;
                default:
                begin
                    if (count_reg >= OFS_SRC && count_reg < OFS_DST)
                        hdr_next.source = {hdr_reg.source[23:0], byte_in.byte_value};
                    else if (count_reg >= OFS_DST && count_reg < OFS_HDR_END)
                        hdr_next.destination = {hdr_reg.destination[23:0],
                                                byte_in.byte_value};
                end
            endcase
            if (!count_reg[0])
                pending_next = byte_in.byte_value;
            else if (count_reg < {10'd0, hlen_cur} && count_reg != OFS_CSUM_LO)
                hdr_next.sum = sum_folded;
        end
    end

    ipv4hc_verdict u_verdict (
        .hdr      (hdr_next),
        .received (count_next),
        .status   (status_next)
    );

    assign out_valid_next = done ? 1'b1 : (verdict.ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            pending_reg   <= '0;
            hdr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (done)
            begin
                count_reg   <= '0;
                pending_reg <= '0;
                hdr_reg     <= '0;
            end
            else
            begin
                count_reg   <= count_next;
                pending_reg <= pending_next;
                hdr_reg     <= hdr_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (done)
        begin
            status_reg  <= status_next;
            out_hdr_reg <= hdr_next;
        end
    end

    assign verdict.valid           = out_valid_reg;
    assign verdict.status          = status_reg;
    assign verdict.protocol_number = out_hdr_reg.protocol;
    assign verdict.tot_len         = out_hdr_reg.tot_len;
    assign verdict.header_length   = {out_hdr_reg.first_byte[3:0], 2'b00};
    assign verdict.identification  = out_hdr_reg.identification;
    assign verdict.flag_bits       = out_hdr_reg.flags_offset[15:13];
    assign verdict.ttl_value       = out_hdr_reg.ttl;
    assign verdict.src_addr        = out_hdr_reg.source;
    assign verdict.dst_addr        = out_hdr_reg.destination;

    // a final byte always produces a verdict word next cycle
    a_done_gives_verdict: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> verdict.valid)
        else $error("final byte did not produce a verdict word");

    // packet state starts over after a verdict
    a_done_clears_count: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> (count_reg == 16'd0 && hdr_reg.sum == 16'd0))
        else $error("packet state not cleared after verdict");

    // middle bytes advance the count until it saturates
    a_count_advances: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !byte_in.last_byte && count_reg != COUNT_MAX)
            |=> count_reg == $past(count_reg) + 16'd1)
        else $error("byte count did not advance");

    // the verdict register is never overwritten while stalled
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !verdict.ready) |-> !accept)
        else $error("input accepted while verdict word was stalled");

endmodule

// ===== sim/ipv4hc_verdict_monitor.sv =====
// Watches the byte and verdict channels, predicts each verdict word and compares it.
module ipv4hc_verdict_monitor (
    input  logic       clk,
    input  logic       rst_n,
    ipv4hc_byte_if     byte_mon,
    ipv4hc_verdict_if  verdict_mon,
    output int         error_total,
    output int         verdicts_due
);
    import ipv4hc_pkg::*;

    typedef struct packed {
        status_t     status;
        logic [7:0]  protocol_number;
        logic [15:0] tot_len;
        logic [5:0]  header_length;
        logic [15:0] identification;
        logic [2:0]  flag_bits;
        logic [7:0]  ttl_value;
        logic [31:0] src_addr;
        logic [31:0] dst_addr;
    } verdict_t;

    verdict_t    awaited_verdicts[$];

    logic [15:0] rx_count;
    logic [16:0] word_sum;
    logic [7:0]  high_half;
    logic [7:0]  ver_ihl;
    logic [15:0] csum_field;
    logic [15:0] tlen_field;
    logic [15:0] id_field;
    logic [15:0] frag_field;
    logic [7:0]  ttl_field;
    logic [7:0]  proto_field;
    logic [31:0] src_field;
    logic [31:0] dst_field;

    task automatic clear_header();
        rx_count    = '0;
        word_sum    = '0;
        high_half   = '0;
        ver_ihl     = '0;
        csum_field  = '0;
        tlen_field  = '0;
        id_field    = '0;
        frag_field  = '0;
        ttl_field   = '0;
        proto_field = '0;
        src_field   = '0;
        dst_field   = '0;
    endtask

    // Fold one packet byte into the header state; the final byte yields a verdict.
    task automatic take_packet_byte(input logic [7:0] b, input logic is_last);
        logic [15:0] idx;
        logic [16:0] folded;
        logic [5:0]  hdr_bytes;
        logic [15:0] want_csum;
        verdict_t    v;
        idx = rx_count;
        if (idx != COUNT_MAX)
        begin
            case (idx)
                OFS_VER_IHL: ver_ihl = b;
                OFS_TLEN_HI: tlen_field[15:8] = b;
                OFS_TLEN_LO: tlen_field[7:0] = b;
                OFS_ID_HI:   id_field[15:8] = b;
                OFS_ID_LO:   id_field[7:0] = b;
                OFS_FRAG_HI: frag_field[15:8] = b;
                OFS_FRAG_LO: frag_field[7:0] = b;
                OFS_TTL:     ttl_field = b;
                OFS_PROTO:   proto_field = b;
                OFS_CSUM_HI: csum_field[15:8] = b;
                OFS_CSUM_LO: csum_field[7:0] = b;
                default:
                begin
                    if (idx >= OFS_SRC && idx < OFS_DST)
                        src_field = {src_field[23:0], b};
                    else if (idx >= OFS_DST && idx < OFS_HDR_END)
                        dst_field = {dst_field[23:0], b};
                end
            endcase
            hdr_bytes = {ver_ihl[3:0], 2'b00};
            if (!idx[0])
                high_half = b;
            else if (idx < hdr_bytes && idx != OFS_CSUM_LO)
            begin
                folded = word_sum + {high_half, b};
                if (folded[16])
                    folded = {1'b0, folded[15:0]} + 17'd1;
                word_sum = folded;
            end
            rx_count = idx + 16'd1;
        end
        if (is_last)
        begin
            hdr_bytes = {ver_ihl[3:0], 2'b00};
            want_csum = ~word_sum[15:0];
            if (ver_ihl[7:4] != IP_VERSION)
                v.status = ST_BAD_VERSION;
            else if (hdr_bytes < MIN_HDR_LEN || {10'd0, hdr_bytes} > rx_count)
                v.status = ST_BAD_HDR_LEN;
            else if (csum_field != want_csum)
                v.status = ST_BAD_CHECKSUM;
            else if (tlen_field > rx_count)
                v.status = ST_BAD_TOTAL_LEN;
            else if (frag_field[12:0] != NO_FRAG_OFS)
                v.status = ST_FRAGMENT;
            else if (proto_field == PROTO_UDP)
                v.status = ST_UDP;
            else if (proto_field == PROTO_ICMP)
                v.status = ST_ICMP;
            else if (proto_field == PROTO_TCP)
                v.status = ST_TCP;
            else
                v.status = ST_UNKNOWN_PROTO;
            v.protocol_number = proto_field;
            v.tot_len         = tlen_field;
            v.header_length   = hdr_bytes;
            v.identification  = id_field;
            v.flag_bits       = frag_field[15:13];
            v.ttl_value       = ttl_field;
            v.src_addr        = src_field;
            v.dst_addr        = dst_field;
            awaited_verdicts.push_back(v);
            clear_header();
        end
    endtask

    task automatic report_error(input string what, input bit have_want,
                                input verdict_t want, input verdict_t got);
        error_total++;
        if (error_total <= 10)
        begin
            $display("ERROR %s", what);
            if (have_want)
                $display("  exp st=%0d proto=%h tlen=%h hlen=%0d id=%h flg=%h ttl=%h src=%h dst=%h",
                         want.status, want.protocol_number, want.tot_len,
                         want.header_length, want.identification, want.flag_bits,
                         want.ttl_value, want.src_addr, want.dst_addr);
            $display("  got st=%0d proto=%h tlen=%h hlen=%0d id=%h flg=%h ttl=%h src=%h dst=%h",
                     got.status, got.protocol_number, got.tot_len,
                     got.header_length, got.identification, got.flag_bits,
                     got.ttl_value, got.src_addr, got.dst_addr);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        verdict_t got;
        verdict_t want;
        if (!rst_n)
        begin
            clear_header();
            awaited_verdicts.delete();
            error_total = 0;
        end
        else
        begin
            // verdict first: a word leaving now never belongs to a byte taken now
            if (verdict_mon.valid && verdict_mon.ready)
            begin
                got.status          = status_t'(verdict_mon.status);
                got.protocol_number = verdict_mon.protocol_number;
                got.tot_len         = verdict_mon.tot_len;
                got.header_length   = verdict_mon.header_length;
                got.identification  = verdict_mon.identification;
                got.flag_bits       = verdict_mon.flag_bits;
                got.ttl_value       = verdict_mon.ttl_value;
                got.src_addr        = verdict_mon.src_addr;
                got.dst_addr        = verdict_mon.dst_addr;
                if (awaited_verdicts.size() == 0)
                    report_error("verdict word with none outstanding", 1'b0, got, got);
                else
                begin
                    want = awaited_verdicts.pop_front();
                    if (got !== want)
                        report_error("verdict word mismatch", 1'b1, want, got);
                end
            end
            if (byte_mon.valid && byte_mon.ready)
                take_packet_byte(byte_mon.byte_value, byte_mon.last_byte);
        end
        verdicts_due = awaited_verdicts.size();
    end

endmodule

// ===== sim/tb.sv =====
// Testbench top: clock, reset, packet stimulus, output backpressure and the verdict.
module tb;
    import ipv4hc_pkg::*;

    localparam int CYCLE_LIMIT = 500000;
    localparam int RANDOM_BYTES = 1700;

    logic clk;
    logic rst_n;
    int   errors;
    int   due;
    int   cycle_count = 0;
    int   verdicts_taken = 0;
    logic calm;

    logic [7:0] pkt[$];

    ipv4hc_byte_if    byte_ch();
    ipv4hc_verdict_if verdict_ch();

    ipv4_header_checker i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .byte_in (byte_ch),
        .verdict (verdict_ch)
    );

    ipv4hc_verdict_monitor i_mon (
        .clk          (clk),
        .rst_n        (rst_n),
        .byte_mon     (byte_ch),
        .verdict_mon  (verdict_ch),
        .error_total  (errors),
        .verdicts_due (due)
    );

    // no idling on either side during this stretch
    assign calm = (verdicts_taken >= 30 && verdicts_taken < 40);

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (rst_n && verdict_ch.valid && verdict_ch.ready)
            verdicts_taken <= verdicts_taken + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // verdict sink: random stalls, one long hold-off to back the block up
    initial
    begin
        int hold_left;
        bit hold_used;
        hold_left = 0;
        hold_used = 0;
        verdict_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!hold_used && verdicts_taken == 20)
            begin
                hold_used = 1;
                hold_left = 400;
            end
            if (hold_left > 0)
            begin
                verdict_ch.ready <= 1'b0;
                hold_left--;
            end
            else if (calm)
                verdict_ch.ready <= 1'b1;
            else
                verdict_ch.ready <= ($urandom_range(99) >= 26);
        end
    end

    // Recompute the header checksum over the words the IHL nibble covers.
    task automatic seal_checksum();
        logic [7:0]  first;
        logic [16:0] acc;
        int          hl;
        first = pkt[0];
        hl = first[3:0] * 4;
        acc = '0;
        for (int i = 0; i + 1 < hl && i + 1 < pkt.size(); i += 2)
        begin
            if (i != OFS_CSUM_HI)
            begin
                acc = acc + {pkt[i], pkt[i+1]};
                if (acc[16])
                    acc = {1'b0, acc[15:0]} + 17'd1;
            end
        end
        if (pkt.size() > OFS_CSUM_LO)
        begin
            pkt[OFS_CSUM_HI] = ~acc[15:8];
            pkt[OFS_CSUM_LO] = ~acc[7:0];
        end
    endtask

    task automatic build_header(input int ihl, input logic [7:0] proto,
                                input int payload, input logic [15:0] frag);
        logic [3:0]  ihl_bits;
        logic [15:0] tl;
        logic [15:0] id;
        int          hl;
        ihl_bits = 4'(ihl);
        hl = ihl * 4;
        tl = 16'(hl + payload);
        id = 16'($urandom);
        pkt.delete();
        pkt.push_back({IP_VERSION, ihl_bits});
        pkt.push_back(8'($urandom));
        pkt.push_back(tl[15:8]);
        pkt.push_back(tl[7:0]);
        pkt.push_back(id[15:8]);
        pkt.push_back(id[7:0]);
        pkt.push_back(frag[15:8]);
        pkt.push_back(frag[7:0]);
        pkt.push_back(8'($urandom));
        pkt.push_back(proto);
        pkt.push_back(8'h00);
        pkt.push_back(8'h00);
        repeat (8) pkt.push_back(8'($urandom));
        while (pkt.size() < hl)
            pkt.push_back(8'($urandom));
        repeat (payload) pkt.push_back(8'($urandom));
        seal_checksum();
    endtask

    task automatic set_total_length(input int n);
        logic [15:0] tl;
        tl = 16'(n);
        pkt[OFS_TLEN_HI] = tl[15:8];
        pkt[OFS_TLEN_LO] = tl[7:0];
        seal_checksum();
    endtask

    task automatic set_version(input logic [3:0] ver);
        logic [7:0] first;
        first = pkt[0];
        first[7:4] = ver;
        pkt[0] = first;
        seal_checksum();
    endtask

    task automatic send_byte(input logic [7:0] value, input logic is_last);
        while (!calm && $urandom_range(99) < 26)
        begin
            byte_ch.valid <= 1'b0;
            @(negedge clk);
        end
        byte_ch.valid      <= 1'b1;
        byte_ch.byte_value <= value;
        byte_ch.last_byte  <= is_last;
        @(posedge clk);
        while (!byte_ch.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic send_packet();
        foreach (pkt[i])
            send_byte(pkt[i], i == pkt.size() - 1);
    endtask

    task automatic send_random_packet();
        int          kind;
        int          ihl;
        int          hl;
        int          pos;
        logic [7:0]  proto;
        logic [7:0]  first;
        logic [7:0]  tmp;
        logic [15:0] frag;
        logic [3:0]  ver;
        kind = $urandom_range(99);
        ihl = ($urandom_range(3) == 0) ? $urandom_range(15, 6) : 5;
        case ($urandom_range(3))
            0: proto = PROTO_UDP;
            1: proto = PROTO_ICMP;
            2: proto = PROTO_TCP;
            default: proto = 8'($urandom);
        endcase
        frag = 16'($urandom);
        frag[12:0] = '0;
        build_header(ihl, proto, $urandom_range(24), frag);
        hl = ihl * 4;
        if (kind < 55)
            repeat ($urandom_range(3)) pkt.push_back(8'($urandom));
        else if (kind < 63)
        begin
            pos = $urandom_range(hl - 1, 1);
            tmp = pkt[pos];
            tmp[$urandom_range(7)] ^= 1'b1;
            pkt[pos] = tmp;
        end
        else if (kind < 70)
            set_total_length((pkt.size() + 1 + $urandom_range(200)) & 16'hffff);
        else if (kind < 77)
        begin
            tmp = pkt[OFS_FRAG_HI];
            tmp[4:0] = 5'($urandom);
            pkt[OFS_FRAG_HI] = tmp;
            pkt[OFS_FRAG_LO] = 8'($urandom);
            if (tmp[4:0] == 5'd0 && pkt[OFS_FRAG_LO] == 8'd0)
                pkt[OFS_FRAG_LO] = 8'd1;
            seal_checksum();
        end
        else if (kind < 82)
        begin
            ver = 4'($urandom);
            if (ver == IP_VERSION)
                ver = ~ver;
            set_version(ver);
        end
        else if (kind < 87)
        begin
            first = pkt[0];
            first[3:0] = 4'($urandom_range(4));
            pkt[0] = first;
            seal_checksum();
        end
        else if (kind < 93)
        begin
            while (pkt.size() > hl - 1)
                void'(pkt.pop_back());
            while (pkt.size() > 1 && $urandom_range(1))
                void'(pkt.pop_back());
        end
        else
        begin
            pkt.delete();
            repeat ($urandom_range(40, 1)) pkt.push_back(8'($urandom));
            if ($urandom_range(1))
                pkt[0] = {IP_VERSION, 4'd5};
        end
        send_packet();
    endtask

    initial
    begin
        int random_sent;
        rst_n = 1'b0;
        byte_ch.valid = 1'b0;
        byte_ch.byte_value = 8'h00;
        byte_ch.last_byte = 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // plain UDP, minimum header, nothing after it
        build_header(5, PROTO_UDP, 0, 16'h0000);
        send_packet();
        // longest header with options, DF set
        build_header(15, PROTO_ICMP, 4, 16'h4000);
        send_packet();
        // all flag bits set, offset zero: still a whole datagram
        build_header(5, PROTO_TCP, 8, 16'he000);
        send_packet();
        build_header(5, 8'hff, 0, 16'h0000);
        send_packet();
        build_header(5, 8'h00, 2, 16'h0000);
        send_packet();
        build_header(5, PROTO_UDP, 0, 16'h0000);
        set_version(4'hf);
        send_packet();
        build_header(5, PROTO_UDP, 0, 16'h0000);
        set_version(4'h0);
        send_packet();
        // IHL below five, and zero
        build_header(4, PROTO_UDP, 0, 16'h0000);
        send_packet();
        build_header(0, PROTO_TCP, 0, 16'h0000);
        send_packet();
        // lone byte: header cut short
        pkt.delete();
        pkt.push_back({IP_VERSION, 4'd5});
        send_packet();
        build_header(5, PROTO_UDP, 3, 16'h0000);
        pkt[OFS_CSUM_LO] = pkt[OFS_CSUM_LO] ^ 8'h01;
        send_packet();
        build_header(5, PROTO_UDP, 3, 16'h0000);
        set_total_length(pkt.size() + 1);
        send_packet();
        // offset bits in the low byte, then only in the high byte
        build_header(5, PROTO_UDP, 0, 16'h0001);
        send_packet();
        build_header(5, PROTO_TCP, 0, 16'h3f00);
        send_packet();

        random_sent = 0;
        while (random_sent < RANDOM_BYTES)
        begin
            send_random_packet();
            random_sent += pkt.size();
        end
        byte_ch.valid <= 1'b0;

        while (due != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);
        if (errors == 0 && due == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
